// ----- rtl/core/ofs_pkg.sv -----
// Shared types and constants for the occupancy frontier select block.
// Used by ofs_cell and the top level; no dependencies.
`default_nettype none
package ofs_pkg;

	// 2-bit class kept per stored grid cell
	localparam logic [1:0] CLS_FREE     = 2'd0;
	localparam logic [1:0] CLS_UNKNOWN  = 2'd1;
	localparam logic [1:0] CLS_OCCUPIED = 2'd2;
	localparam logic [1:0] CLS_OTHER    = 2'd3;

	// raw occupancy values
	localparam logic signed [7:0] VAL_UNKNOWN  = -8'sd1;
	localparam logic signed [7:0] VAL_FREE     = 8'sd0;
	localparam logic signed [7:0] VAL_OCCUPIED = 8'sd100;

	// configuration register indexes
	localparam int CFG_IDX_W = 4;
	localparam int CFG_DATA_W = 24;
	localparam logic [CFG_IDX_W-1:0] REG_GRID_WIDTH    = 4'd0;
	localparam logic [CFG_IDX_W-1:0] REG_GRID_HEIGHT   = 4'd1;
	localparam logic [CFG_IDX_W-1:0] REG_CELL_SIZE     = 4'd2;
	localparam logic [CFG_IDX_W-1:0] REG_ORIGIN_X      = 4'd3;
	localparam logic [CFG_IDX_W-1:0] REG_ORIGIN_Y      = 4'd4;
	localparam logic [CFG_IDX_W-1:0] REG_SAFETY_RADIUS = 4'd5;
	localparam logic [CFG_IDX_W-1:0] REG_ROBOT_X       = 4'd6;
	localparam logic [CFG_IDX_W-1:0] REG_ROBOT_Y       = 4'd7;

	// centre positions saturate at +-POS_LIMIT (0.1 mm)
	localparam int POS_LIMIT = 8000000;

	// per-column summary of the window rows around the row being judged
	typedef struct packed {
		logic valid;   // column inside the grid
		logic occ;     // occupied cell in window rows
		logic fv;      // free cell one row above or below
		logic f3;      // free cell in judged row or one above/below
		logic unk;     // judged-row cell is unknown
	} col_t;

endpackage
`default_nettype wire

// ----- rtl/core/ofs_line_store.sv -----
// Line store: one 2-bit RAM bank per stored grid row, all banks read at one column.
// No package dependencies.
`default_nettype none
module ofs_line_store #(
	parameter int ROWS = 15,
	parameter int DEPTH = 512,
	localparam int BW = $clog2(ROWS),
	localparam int AW = $clog2(DEPTH)
) (
	input  wire logic                  clk,
	input  wire logic                  wr_en,
	input  wire logic [BW-1:0]         wr_bank,
	input  wire logic [AW-1:0]         wr_addr,
	input  wire logic [1:0]            wr_data,
	input  wire logic [AW-1:0]         rd_addr,
	output logic [ROWS-1:0][1:0]       rd_data
);

	for (genvar b = 0; b < ROWS; b++) begin : g_bank
		logic [1:0] mem [DEPTH];
		logic [1:0] rd_q;

		always_ff @(posedge clk) begin
			if (wr_en && (wr_bank == BW'(b))) begin
				mem[wr_addr] <= wr_data;
			end
			rd_q <= mem[rd_addr];
		end

		assign rd_data[b] = rd_q;
	end

endmodule
`default_nettype wire

// ----- rtl/core/ofs_cell.sv -----
// One cell of the column chain: holds a column summary, hands it on each cycle,
// and flags an obstacle when its column lies inside the radius. Uses ofs_pkg.
`default_nettype none
module ofs_cell #(
	parameter int OFFSET = 0,
	parameter int RW = 3
) (
	input  wire logic           clk,
	input  wire logic           arst_n,
	input  wire ofs_pkg::col_t  d,
	input  wire logic [RW-1:0]  radius,
	output ofs_pkg::col_t       q,
	output logic                occ_hit
);

	localparam int ABS_OFF = (OFFSET < 0) ? -OFFSET : OFFSET;

	ofs_pkg::col_t cell_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cell_q <= '0;
		end else begin
			cell_q <= d;
		end
	end

	assign q = cell_q;
	assign occ_hit = cell_q.valid && cell_q.occ && (ABS_OFF <= int'(radius));

endmodule
`default_nettype wire

// ----- rtl/core/occupancy_frontier_farthest_select_unit.sv -----
// Top level of the frontier select block: config registers, line store, column chain,
// goal arithmetic and result register. Uses ofs_pkg, ofs_line_store, ofs_cell.
//
// Usage:
//  - Input channel (in_valid/in_stall, cell_value) takes one grid cell per word in
//    raster order. Cells of a row are taken one per cycle.
//  - After a row ends, the row lying max(radius,1) rows back is judged: a column sweep
//    through the line store and the cell chain, during which in_stall is high. The
//    sweep runs on past the last column to cover the read stage, the chain depth and
//    the goal pipeline tail.
//  - On the last cell of a frame the remaining rows are judged (one sweep each), then
//    the goal centre is rebuilt once the result register is free; the result word then
//    appears on out_valid with found/goal fields.
//  - A held result (out_stall high) does not block new cells; a next frame's result
//    waits until the previous one is taken.
//  - Reset (arst_n low) loads default config and starts an empty frame. Writing grid
//    width, height or safety radius restarts the frame. Config writes are taken any
//    cycle via cfg_wr_en/cfg_index/cfg_data.
`default_nettype none
module occupancy_frontier_farthest_select_unit #(
	parameter int MAX_WIDTH = 512,
	parameter int MAX_HEIGHT = 512,
	parameter int MAX_RADIUS = 7
) (
	input  wire logic                               clk,
	input  wire logic                               arst_n,
	input  wire logic                               cfg_wr_en,
	input  wire logic [ofs_pkg::CFG_IDX_W-1:0]      cfg_index,
	input  wire logic [ofs_pkg::CFG_DATA_W-1:0]     cfg_data,
	input  wire logic                               in_valid,
	output logic                                    in_stall,
	input  wire logic signed [7:0]                  cell_value,
	output logic                                    out_valid,
	input  wire logic                               out_stall,
	output logic                                    found,
	output logic [8:0]                              goal_cell_x,
	output logic [8:0]                              goal_cell_y,
	output logic signed [23:0]                      goal_x_pos,
	output logic signed [23:0]                      goal_y_pos
);

	localparam int M    = MAX_RADIUS;
	localparam int ROWS = 2 * MAX_RADIUS + 1;
	localparam int NC   = 2 * MAX_RADIUS + 1;
	localparam int CW   = $clog2(MAX_WIDTH);
	localparam int RHW  = $clog2(MAX_HEIGHT);
	localparam int IW   = (CW > RHW) ? CW : RHW;
	localparam int WEW  = $clog2(MAX_WIDTH + 1);
	localparam int HEW  = $clog2(MAX_HEIGHT + 1);
	localparam int RW   = $clog2(MAX_RADIUS + 1);
	localparam int BW   = $clog2(ROWS);
	localparam int XW   = $clog2(MAX_WIDTH + 2 * MAX_RADIUS + 10);
	localparam int PW   = IW + 14;
	localparam int SW   = ((PW > 24) ? PW : 24) + 2;
	localparam int TAIL = 2 * MAX_RADIUS + 8;

	localparam logic signed [SW-1:0] POS_HI = SW'(ofs_pkg::POS_LIMIT);
	localparam logic signed [SW-1:0] POS_LO = -SW'(ofs_pkg::POS_LIMIT);

	typedef enum logic [3:0] {
		ST_IDLE  = 4'b0001,
		ST_SWEEP = 4'b0010,
		ST_EMIT  = 4'b0100,
		ST_DRAIN = 4'b1000
	} state_t;

	// configuration
	logic [9:0]         gw_q, gh_q;
	logic [13:0]        cs_q;
	logic signed [21:0] ox_q, oy_q;
	logic [2:0]         sr_q;
	logic signed [23:0] rx_q, ry_q;

	logic [WEW-1:0] w_eff;
	logic [HEW-1:0] h_eff;
	logic [RW-1:0]  r_eff;
	logic [RW-1:0]  lag;

	// control
	state_t         state_q;
	logic [CW-1:0]  col_q;
	logic [RHW-1:0] row_q;
	logic [BW-1:0]  wb_q;
	logic [HEW-1:0] je_q;
	logic [BW-1:0]  jb_q;
	logic           frame_end_q;
	logic [XW-1:0]  x_q;

	logic cfg_restart, emit_load, frame_clr, accept, col_last, row_last, sweep_done;
	logic [1:0] cls;

	// best frontier
	logic          best_valid_q;
	logic [48:0]   best_d_q;
	logic [IW-1:0] best_col_q, best_row_q;

	// read stage
	logic            rd_vld_s1;
	logic [XW-1:0]   rd_x_s1;
	logic [ROWS-1:0][1:0] rd_data;

	ofs_pkg::col_t col_in;
	ofs_pkg::col_t chain [NC];
	logic [NC-1:0] occ_hit;
	logic          near_free, is_frontier;
	logic [XW-1:0] xc;

	// goal pipeline
	logic              g_vld_s1, g_emit_s1, g_found_s1;
	logic [IW-1:0]     g_col_s1, g_row_s1;
	logic              g_vld_s2, g_emit_s2, g_found_s2;
	logic [IW-1:0]     g_col_s2, g_row_s2;
	logic [PW-1:0]     px_s2, py_s2;
	logic              g_vld_s3, g_emit_s3, g_found_s3;
	logic [IW-1:0]     g_col_s3, g_row_s3;
	logic signed [23:0] cx_s3, cy_s3;
	logic              g_vld_s4;
	logic [IW-1:0]     g_col_s4, g_row_s4;
	logic [23:0]       ax_s4, ay_s4;
	logic              g_vld_s5;
	logic [IW-1:0]     g_col_s5, g_row_s5;
	logic [47:0]       sqx_s5, sqy_s5;
	logic              g_vld_s6;
	logic [IW-1:0]     g_col_s6, g_row_s6;
	logic [48:0]       d_s6;

	logic signed [SW-1:0] sum_x, sum_y;
	logic signed [24:0]   dx, dy;

	// result register
	logic               out_valid_q, found_q;
	logic [8:0]         goal_cell_x_q, goal_cell_y_q;
	logic signed [23:0] goal_x_pos_q, goal_y_pos_q;

	// ---------------- configuration ----------------
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			gw_q <= 10'd512;
			gh_q <= 10'd512;
			cs_q <= 14'd500;
			ox_q <= '0;
			oy_q <= '0;
			sr_q <= 3'd3;
			rx_q <= '0;
			ry_q <= '0;
		end else if (cfg_wr_en) begin
			unique case (cfg_index)
				ofs_pkg::REG_GRID_WIDTH:    gw_q <= cfg_data[9:0];
				ofs_pkg::REG_GRID_HEIGHT:   gh_q <= cfg_data[9:0];
				ofs_pkg::REG_CELL_SIZE:     cs_q <= cfg_data[13:0];
				ofs_pkg::REG_ORIGIN_X:      ox_q <= cfg_data[21:0];
				ofs_pkg::REG_ORIGIN_Y:      oy_q <= cfg_data[21:0];
				ofs_pkg::REG_SAFETY_RADIUS: sr_q <= cfg_data[2:0];
				ofs_pkg::REG_ROBOT_X:       rx_q <= cfg_data[23:0];
				ofs_pkg::REG_ROBOT_Y:       ry_q <= cfg_data[23:0];
				default: ;
			endcase
		end
	end

	assign cfg_restart = cfg_wr_en && ((cfg_index == ofs_pkg::REG_GRID_WIDTH) ||
		(cfg_index == ofs_pkg::REG_GRID_HEIGHT) || (cfg_index == ofs_pkg::REG_SAFETY_RADIUS));

	always_comb begin
		if (gw_q == 10'd0) w_eff = WEW'(1);
		else if (32'(gw_q) > 32'(MAX_WIDTH)) w_eff = WEW'(MAX_WIDTH);
		else w_eff = WEW'(gw_q);
		if (gh_q == 10'd0) h_eff = HEW'(1);
		else if (32'(gh_q) > 32'(MAX_HEIGHT)) h_eff = HEW'(MAX_HEIGHT);
		else h_eff = HEW'(gh_q);
		if (32'(sr_q) > 32'(MAX_RADIUS)) r_eff = RW'(MAX_RADIUS);
		else r_eff = RW'(sr_q);
		lag = (r_eff == '0) ? RW'(1) : r_eff;
	end

	// ---------------- input and control ----------------
	assign in_stall = (state_q != ST_IDLE);
	assign accept = in_valid && !in_stall;

	always_comb begin
		if (cell_value == ofs_pkg::VAL_UNKNOWN) cls = ofs_pkg::CLS_UNKNOWN;
		else if (cell_value == ofs_pkg::VAL_FREE) cls = ofs_pkg::CLS_FREE;
		else if (cell_value == ofs_pkg::VAL_OCCUPIED) cls = ofs_pkg::CLS_OCCUPIED;
		else cls = ofs_pkg::CLS_OTHER;
	end

	assign col_last = (32'(col_q) + 32'd1) >= 32'(w_eff);
	assign row_last = (32'(row_q) + 32'd1) >= 32'(h_eff);
	assign sweep_done = (32'(x_q) == (32'(w_eff) + 32'(TAIL)));
	assign emit_load = (state_q == ST_EMIT) && !out_valid_q;
	assign frame_clr = cfg_restart || emit_load;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			col_q       <= '0;
			row_q       <= '0;
			wb_q        <= '0;
			je_q        <= '0;
			jb_q        <= '0;
			frame_end_q <= 1'b0;
			x_q         <= '0;
		end else if (frame_clr) begin
			col_q       <= '0;
			row_q       <= '0;
			wb_q        <= '0;
			je_q        <= '0;
			jb_q        <= '0;
			frame_end_q <= 1'b0;
			if (emit_load) begin
				state_q <= ST_DRAIN;
			end
		end else begin
			unique case (state_q)
				ST_IDLE: begin
					if (accept) begin
						if (!col_last) begin
							col_q <= col_q + CW'(1);
						end else begin
							col_q <= '0;
							x_q   <= '0;
							if (row_last) begin
								frame_end_q <= 1'b1;
								state_q     <= ST_SWEEP;
							end else begin
								row_q <= row_q + RHW'(1);
								wb_q  <= (32'(wb_q) == ROWS - 1) ? '0 : wb_q + BW'(1);
								if (32'(row_q) >= 32'(lag)) begin
									state_q <= ST_SWEEP;
								end
							end
						end
					end
				end
				ST_SWEEP: begin
					if (sweep_done) begin
						je_q <= je_q + HEW'(1);
						jb_q <= (32'(jb_q) == ROWS - 1) ? '0 : jb_q + BW'(1);
						x_q  <= '0;
						if (!frame_end_q) begin
							state_q <= ST_IDLE;
						end else if ((32'(je_q) + 32'd1) < 32'(h_eff)) begin
							state_q <= ST_SWEEP;
						end else begin
							state_q <= ST_EMIT;
						end
					end else begin
						x_q <= x_q + XW'(1);
					end
				end
				ST_EMIT: ;
				ST_DRAIN: begin
					if (g_vld_s3 && g_emit_s3) begin
						state_q <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	// ---------------- line store ----------------
	ofs_line_store #(
		.ROWS  (ROWS),
		.DEPTH (MAX_WIDTH)
	) u_store (
		.clk     (clk),
		.wr_en   (accept),
		.wr_bank (wb_q),
		.wr_addr (col_q),
		.wr_data (cls),
		.rd_addr (CW'(x_q)),
		.rd_data (rd_data)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rd_vld_s1 <= 1'b0;
			rd_x_s1   <= '0;
		end else begin
			rd_vld_s1 <= (state_q == ST_SWEEP);
			rd_x_s1   <= x_q;
		end
	end

	// column summary over the banks; each bank maps to one row offset from the judged row
	always_comb begin
		int d;
		int y;
		logic occ, fv, ctr_free, unk;
		occ = 1'b0;
		fv = 1'b0;
		ctr_free = 1'b0;
		unk = 1'b0;
		for (int b = 0; b < ROWS; b++) begin
			d = b - int'(jb_q);
			if (d > M) d = d - ROWS;
			else if (d < -M) d = d + ROWS;
			y = int'(je_q) + d;
			if (y >= 0 && y < int'(h_eff)) begin
				if (d <= int'(r_eff) && d >= -int'(r_eff) &&
					rd_data[b] == ofs_pkg::CLS_OCCUPIED) begin
					occ = 1'b1;
				end
				if ((d == 1 || d == -1) && rd_data[b] == ofs_pkg::CLS_FREE) begin
					fv = 1'b1;
				end
				if (d == 0) begin
					ctr_free = (rd_data[b] == ofs_pkg::CLS_FREE);
					unk = (rd_data[b] == ofs_pkg::CLS_UNKNOWN);
				end
			end
		end
		col_in.valid = rd_vld_s1 && (32'(rd_x_s1) < 32'(w_eff));
		col_in.occ   = occ;
		col_in.fv    = fv;
		col_in.f3    = fv | ctr_free;
		col_in.unk   = unk;
	end

	// ---------------- column chain ----------------
	// cell k holds column x-k-2 (x the sweep counter); the centre cell M holds the column being judged
	for (genvar k = 0; k < NC; k++) begin : g_chain
		if (k == 0) begin : g_head
			ofs_cell #(.OFFSET(M - k), .RW(RW)) u_cell (
				.clk (clk), .arst_n (arst_n), .d (col_in), .radius (r_eff),
				.q (chain[k]), .occ_hit (occ_hit[k])
			);
		end else begin : g_body
			ofs_cell #(.OFFSET(M - k), .RW(RW)) u_cell (
				.clk (clk), .arst_n (arst_n), .d (chain[k-1]), .radius (r_eff),
				.q (chain[k]), .occ_hit (occ_hit[k])
			);
		end
	end

	assign near_free = chain[M].fv || (chain[M-1].valid && chain[M-1].f3) ||
		(chain[M+1].valid && chain[M+1].f3);
	assign is_frontier = chain[M].valid && chain[M].unk && near_free && !(|occ_hit);
	assign xc = x_q - XW'(M + 2);

	// ---------------- goal arithmetic ----------------
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			g_vld_s1 <= 1'b0;
			g_vld_s2 <= 1'b0;
			g_vld_s3 <= 1'b0;
			g_vld_s4 <= 1'b0;
			g_vld_s5 <= 1'b0;
			g_vld_s6 <= 1'b0;
		end else begin
			g_vld_s1 <= emit_load || ((state_q == ST_SWEEP) && is_frontier);
			g_vld_s2 <= g_vld_s1;
			g_vld_s3 <= g_vld_s2;
			g_vld_s4 <= g_vld_s3 && !g_emit_s3;
			g_vld_s5 <= g_vld_s4;
			g_vld_s6 <= g_vld_s5;
		end
	end

	always_comb begin
		sum_x = $signed(SW'(px_s2)) + SW'(ox_q) + $signed(SW'(cs_q >> 1));
		sum_y = $signed(SW'(py_s2)) + SW'(oy_q) + $signed(SW'(cs_q >> 1));
		dx = 25'(cx_s3) - 25'(rx_q);
		dy = 25'(cy_s3) - 25'(ry_q);
	end

	always_ff @(posedge clk) begin
		if (emit_load) begin
			g_emit_s1  <= 1'b1;
			g_found_s1 <= best_valid_q;
			g_col_s1   <= best_col_q;
			g_row_s1   <= best_row_q;
		end else begin
			g_emit_s1  <= 1'b0;
			g_found_s1 <= 1'b0;
			g_col_s1   <= IW'(xc);
			g_row_s1   <= IW'(je_q);
		end
		g_emit_s2  <= g_emit_s1;
		g_found_s2 <= g_found_s1;
		g_col_s2   <= g_col_s1;
		g_row_s2   <= g_row_s1;
		px_s2      <= PW'(g_col_s1) * PW'(cs_q);
		py_s2      <= PW'(g_row_s1) * PW'(cs_q);

		g_emit_s3  <= g_emit_s2;
		g_found_s3 <= g_found_s2;
		g_col_s3   <= g_col_s2;
		g_row_s3   <= g_row_s2;
		if (sum_x > POS_HI) cx_s3 <= 24'(POS_HI);
		else if (sum_x < POS_LO) cx_s3 <= 24'(POS_LO);
		else cx_s3 <= 24'(sum_x);
		if (sum_y > POS_HI) cy_s3 <= 24'(POS_HI);
		else if (sum_y < POS_LO) cy_s3 <= 24'(POS_LO);
		else cy_s3 <= 24'(sum_y);

		g_col_s4 <= g_col_s3;
		g_row_s4 <= g_row_s3;
		ax_s4    <= dx[24] ? 24'(-dx) : 24'(dx);
		ay_s4    <= dy[24] ? 24'(-dy) : 24'(dy);

		g_col_s5 <= g_col_s4;
		g_row_s5 <= g_row_s4;
		sqx_s5   <= ax_s4 * ax_s4;
		sqy_s5   <= ay_s4 * ay_s4;

		g_col_s6 <= g_col_s5;
		g_row_s6 <= g_row_s5;
		d_s6     <= 49'(sqx_s5) + 49'(sqy_s5);
	end

	// strictly farther wins, so the first in raster order keeps a tie
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			best_valid_q <= 1'b0;
			best_d_q     <= '0;
			best_col_q   <= '0;
			best_row_q   <= '0;
		end else if (frame_clr) begin
			best_valid_q <= 1'b0;
			best_d_q     <= '0;
			best_col_q   <= '0;
			best_row_q   <= '0;
		end else if (g_vld_s6 && (!best_valid_q || d_s6 > best_d_q)) begin
			best_valid_q <= 1'b1;
			best_d_q     <= d_s6;
			best_col_q   <= g_col_s6;
			best_row_q   <= g_row_s6;
		end
	end

	// ---------------- result register ----------------
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (g_vld_s3 && g_emit_s3) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (g_vld_s3 && g_emit_s3) begin
			found_q       <= g_found_s3;
			goal_cell_x_q <= g_found_s3 ? 9'(g_col_s3) : 9'd0;
			goal_cell_y_q <= g_found_s3 ? 9'(g_row_s3) : 9'd0;
			goal_x_pos_q  <= g_found_s3 ? cx_s3 : 24'sd0;
			goal_y_pos_q  <= g_found_s3 ? cy_s3 : 24'sd0;
		end
	end

	assign out_valid   = out_valid_q;
	assign found       = found_q;
	assign goal_cell_x = goal_cell_x_q;
	assign goal_cell_y = goal_cell_y_q;
	assign goal_x_pos  = goal_x_pos_q;
	assign goal_y_pos  = goal_y_pos_q;

	// ---------------- assertions ----------------
	a_out_from_drain: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid_q) |-> $past(state_q == ST_DRAIN))
		else $error("result word raised outside drain");

	a_emit_slot_free: assert property (@(posedge clk) disable iff (!arst_n)
		(g_vld_s3 && g_emit_s3) |-> !out_valid_q)
		else $error("result register busy at emit");

	a_best_in_sweep: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(best_valid_q) |-> $past(state_q == ST_SWEEP))
		else $error("best frontier set outside a sweep");

	a_none_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid_q && !found_q) |-> (goal_x_pos_q == 24'sd0 && goal_cell_x_q == 9'd0))
		else $error("empty result carries a goal");

endmodule
`default_nettype wire

// ----- dv/occupancy_frontier_farthest_select_unit_test.sv -----
`timescale 1ns / 100ps
// Self-checking bench for the occupancy frontier select unit: streams grid frames,
// predicts the farthest safe frontier per frame and checks each result word.
// Depends on ofs_pkg and the top level occupancy_frontier_farthest_select_unit.

typedef struct packed {
	logic               found;
	logic [8:0]         cx;
	logic [8:0]         cy;
	logic signed [23:0] gx;
	logic signed [23:0] gy;
} goal_t;

class frontier_board;
	localparam int MW = 512;
	localparam int MH = 512;
	localparam int MR = 7;
	localparam int ROWS = 2 * MR + 1;

	bit [1:0] cls_store[ROWS*MW];
	int unsigned col_n, row_n;
	bit best_ok;
	longint unsigned best_d;
	int unsigned best_c, best_r;
	int unsigned gw, gh, csz, rad;
	longint ox, oy, rx, ry;
	goal_t goals[$];
	int errors, cells, frames, hits;

	function void restart();
		col_n = 0; row_n = 0; best_ok = 0; best_d = 0; best_c = 0; best_r = 0;
	endfunction

	function void reset_state();
		gw = 512; gh = 512; csz = 500; rad = 3;
		ox = 0; oy = 0; rx = 0; ry = 0;
		restart();
	endfunction

	function int unsigned eff_w();
		if (gw == 0) return 1;
		return gw > MW ? MW : gw;
	endfunction

	function int unsigned eff_h();
		if (gh == 0) return 1;
		return gh > MH ? MH : gh;
	endfunction

	function void write_reg(logic [3:0] idx, logic [23:0] d);
		unique case (idx)
			ofs_pkg::REG_GRID_WIDTH: begin
				gw = d[9:0]; restart();
			end
			ofs_pkg::REG_GRID_HEIGHT: begin
				gh = d[9:0]; restart();
			end
			ofs_pkg::REG_CELL_SIZE: csz = d[13:0];
			ofs_pkg::REG_ORIGIN_X: ox = longint'($signed(d[21:0]));
			ofs_pkg::REG_ORIGIN_Y: oy = longint'($signed(d[21:0]));
			ofs_pkg::REG_SAFETY_RADIUS: begin
				rad = d[2:0]; restart();
			end
			ofs_pkg::REG_ROBOT_X: rx = longint'($signed(d[23:0]));
			ofs_pkg::REG_ROBOT_Y: ry = longint'($signed(d[23:0]));
			default: ;
		endcase
	endfunction

	function longint centre(int unsigned idx, longint org);
		longint v;
		v = longint'(idx) * longint'(csz) + org + longint'(csz / 2);
		if (v > ofs_pkg::POS_LIMIT) v = ofs_pkg::POS_LIMIT;
		if (v < -ofs_pkg::POS_LIMIT) v = -ofs_pkg::POS_LIMIT;
		return v;
	endfunction

	function bit [1:0] cls_at(int c, int r);
		return cls_store[(r % ROWS) * MW + (c % MW)];
	endfunction

	function bit frontier(int c, int e, int w, int h, int r);
		bit near_free;
		int x, y;
		near_free = 0;
		if (cls_at(c, e) != ofs_pkg::CLS_UNKNOWN) return 0;
		for (int dy = -1; dy <= 1; dy++)
			for (int dx = -1; dx <= 1; dx++) begin
				x = c + dx; y = e + dy;
				if ((dx == 0 && dy == 0) || x < 0 || x >= w || y < 0 || y >= h) continue;
				if (cls_at(x, y) == ofs_pkg::CLS_FREE) near_free = 1;
			end
		if (!near_free) return 0;
		for (int dy = -r; dy <= r; dy++)
			for (int dx = -r; dx <= r; dx++) begin
				x = c + dx; y = e + dy;
				if (x < 0 || x >= w || y < 0 || y >= h) continue;
				if (cls_at(x, y) == ofs_pkg::CLS_OCCUPIED) return 0;
			end
		return 1;
	endfunction

	function void judge(int unsigned e, int unsigned w, int unsigned h, int unsigned r);
		longint ax, ay;
		longint unsigned d;
		for (int unsigned c = 0; c < w; c++)
			if (frontier(c, e, w, h, r)) begin
				ax = centre(c, ox) - rx; if (ax < 0) ax = -ax;
				ay = centre(e, oy) - ry; if (ay < 0) ay = -ay;
				d = ax * ax + ay * ay;
				if (!best_ok || d > best_d) begin
					best_ok = 1; best_d = d; best_c = c; best_r = e;
				end
			end
	endfunction

	// one accepted input word
	function void note_cell(logic signed [7:0] v);
		int unsigned w, h, r, lag, e;
		bit [1:0] k;
		goal_t g;
		w = eff_w(); h = eff_h(); r = rad > MR ? MR : rad;
		lag = r < 1 ? 1 : r;
		cells++;
		if (v == ofs_pkg::VAL_UNKNOWN) k = ofs_pkg::CLS_UNKNOWN;
		else if (v == ofs_pkg::VAL_FREE) k = ofs_pkg::CLS_FREE;
		else if (v == ofs_pkg::VAL_OCCUPIED) k = ofs_pkg::CLS_OCCUPIED;
		else k = ofs_pkg::CLS_OTHER;
		if (col_n >= w || row_n >= h) restart();
		cls_store[(row_n % ROWS) * MW + col_n] = k;
		if (col_n + 1 < w) begin
			col_n++;
			return;
		end
		if (row_n >= lag) judge(row_n - lag, w, h, r);
		if (row_n + 1 < h) begin
			col_n = 0; row_n++;
			return;
		end
		// last cell: flush the rows still waiting for judgment
		for (e = (h - 1 >= lag) ? h - lag : 0; e < h; e++) judge(e, w, h, r);
		g = '0;
		if (best_ok) begin
			g.found = 1; g.cx = 9'(best_c); g.cy = 9'(best_r);
			g.gx = 24'(centre(best_c, ox)); g.gy = 24'(centre(best_r, oy));
			hits++;
		end
		frames++;
		goals = {goals, g};
		restart();
	endfunction

	function void cmp(string name, longint e, longint a);
		if (e != a) begin
			$display("%0t: %s mismatch, expected %0d actual %0d", $time, name, e, a);
			errors++;
		end
	endfunction

	function void check(goal_t got);
		goal_t e;
		if (goals.size() == 0) begin
			$display("%0t: unexpected result word, actual found %0d", $time, got.found);
			errors++;
			return;
		end
		e = goals.pop_front();
		cmp("found", e.found, got.found);
		cmp("goal_cell_x", e.cx, got.cx);
		cmp("goal_cell_y", e.cy, got.cy);
		cmp("goal_x_pos", e.gx, got.gx);
		cmp("goal_y_pos", e.gy, got.gy);
	endfunction
endclass

module occupancy_frontier_farthest_select_unit_test;
	localparam int QUIET_LIMIT = 40000;

	logic clk = 0;
	logic arst_n = 0;
	logic cfg_wr_en = 0;
	logic [ofs_pkg::CFG_IDX_W-1:0] cfg_index = '0;
	logic [ofs_pkg::CFG_DATA_W-1:0] cfg_data = '0;
	logic in_valid = 0;
	logic in_stall;
	logic signed [7:0] cell_value = '0;
	logic out_valid;
	logic out_stall = 0;
	logic found;
	logic [8:0] goal_cell_x, goal_cell_y;
	logic signed [23:0] goal_x_pos, goal_y_pos;

	int idle_in, idle_out, quiet;
	frontier_board board;

	occupancy_frontier_farthest_select_unit DUT (
		.clk(clk), .arst_n(arst_n),
		.cfg_wr_en(cfg_wr_en), .cfg_index(cfg_index), .cfg_data(cfg_data),
		.in_valid(in_valid), .in_stall(in_stall), .cell_value(cell_value),
		.out_valid(out_valid), .out_stall(out_stall),
		.found(found), .goal_cell_x(goal_cell_x), .goal_cell_y(goal_cell_y),
		.goal_x_pos(goal_x_pos), .goal_y_pos(goal_y_pos)
	);

	always #1 clk = ~clk;

	always @(posedge clk) begin
		if (arst_n) begin
			if (out_valid && !out_stall)
				board.check({found, goal_cell_x, goal_cell_y, goal_x_pos, goal_y_pos});
			out_stall <= ($urandom_range(99) < idle_out);
		end
	end

	always @(posedge clk) begin
		if ((in_valid && !in_stall) || (out_valid && !out_stall) || cfg_wr_en || !arst_n)
			quiet <= 0;
		else
			quiet <= quiet + 1;
		if (quiet >= QUIET_LIMIT) begin
			$display("%0t: no progress for %0d cycles", $time, quiet);
			$display("occupancy_frontier_farthest_select_unit test failed");
			$finish;
		end
	end

	task send_cell(input logic signed [7:0] v);
		if ($urandom_range(99) < idle_in) begin
			in_valid <= 0;
			do @(posedge clk); while ($urandom_range(99) < idle_in);
		end
		in_valid <= 1;
		cell_value <= v;
		do @(posedge clk); while (in_stall);
		board.note_cell(v);
	endtask

	// block idle: all results in, then room for a trailing sweep
	task settle();
		in_valid <= 0;
		cfg_wr_en <= 0;
		while (board.goals.size() > 0) @(posedge clk);
		repeat (board.eff_w() + 60) @(posedge clk);
	endtask

	task write_reg(input logic [3:0] idx, input logic [23:0] d);
		cfg_wr_en <= 1;
		cfg_index <= idx;
		cfg_data <= d;
		@(posedge clk);
		board.write_reg(idx, d);
	endtask

	task set_grid(input int w, input int h, input int r);
		write_reg(ofs_pkg::REG_GRID_WIDTH, 24'(w));
		write_reg(ofs_pkg::REG_GRID_HEIGHT, 24'(h));
		write_reg(ofs_pkg::REG_SAFETY_RADIUS, 24'(r));
	endtask

	task set_geo(input int s, input int oxv, input int oyv, input int rxv, input int ryv);
		write_reg(ofs_pkg::REG_CELL_SIZE, 24'(s));
		write_reg(ofs_pkg::REG_ORIGIN_X, 24'(oxv));
		write_reg(ofs_pkg::REG_ORIGIN_Y, 24'(oyv));
		write_reg(ofs_pkg::REG_ROBOT_X, 24'(rxv));
		write_reg(ofs_pkg::REG_ROBOT_Y, 24'(ryv));
		cfg_wr_en <= 0;
		@(posedge clk);
	endtask

	function automatic logic signed [7:0] pick_cell(int occ);
		int p;
		p = $urandom_range(99);
		if (p < 40) return ofs_pkg::VAL_UNKNOWN;
		if (p < 70) return ofs_pkg::VAL_FREE;
		if (p < 70 + occ) return ofs_pkg::VAL_OCCUPIED;
		return 8'($urandom_range(255));
	endfunction

	task send_frame(input int occ);
		int n;
		n = board.eff_w() * board.eff_h();
		repeat (n) send_cell(pick_cell(occ));
	endtask

	task random_frame();
		int occ, pick;
		occ = $urandom_range(2) * 4;
		if ($urandom_range(99) < 70) begin
			settle();
			pick = $urandom_range(99);
			set_grid(pick < 3 ? 0 : $urandom_range(1, 10),
				pick > 96 ? 0 : $urandom_range(1, 8), $urandom_range(7));
			if ($urandom_range(9) == 0) write_reg(4'(8 + $urandom_range(7)), 24'($urandom));
			set_geo($urandom_range(9) == 0 ? $urandom_range(16383) : $urandom_range(1, 10000),
				$urandom, $urandom, $urandom, $urandom);
		end
		send_frame(occ);
	endtask

	initial begin
		board = new();
		board.reset_state();
		idle_in = 13;
		idle_out = 72;
		repeat (6) @(posedge clk);
		arst_n <= 1;
		@(posedge clk);

		// mixed extremes of the cell value on a small grid, far corner geometry
		set_grid(4, 3, 0);
		set_geo(10000, 2000000, -2000000, -8000000, 8000000);
		foreach (board.cls_store[i]) ;
		send_cell(-128); send_cell(127); send_cell(0); send_cell(-1);
		send_cell(-1); send_cell(0); send_cell(100); send_cell(-1);
		send_cell(0); send_cell(-1); send_cell(-1); send_cell(5);
		// no frontier at all
		settle();
		set_grid(3, 2, 1);
		set_geo(1, 0, 0, 0, 0);
		repeat (6) send_cell(-1);
		// zero sizes act as a single cell
		settle();
		set_grid(0, 0, 7);
		set_geo(500, 0, 0, 0, 0);
		send_cell(-1);
		// equal distances: the earlier frontier in raster order wins
		settle();
		set_grid(3, 1, 0);
		set_geo(10, 0, 0, 15, 5);
		send_cell(-1); send_cell(0); send_cell(-1);
		// oversize width, widest row
		settle();
		set_grid(1023, 1, 7);
		set_geo(10000, -2000000, 2000000, 8000000, -8000000);
		send_frame(1);
		// tallest grid, one column
		settle();
		set_grid(1, 512, 2);
		set_geo(9999, -1, -1, -1, 1);
		send_frame(2);

		repeat (3) begin
			int goal_cells;
			goal_cells = board.cells + 200;
			while (board.cells < goal_cells) random_frame();
			settle();
			if (idle_in == 13) begin
				idle_in = 72; idle_out = 13;
			end else begin
				idle_in = 0; idle_out = 0;
			end
		end

		settle();
		repeat (100) @(posedge clk);
		$display("%0d cells in %0d frames, %0d frames with a frontier, %0d errors",
			board.cells, board.frames, board.hits, board.errors);
		$display("grid sizes 1..512, radius 0..7, sender and receiver gaps in three phases");
		if (board.errors == 0 && board.goals.size() == 0)
			$display("occupancy_frontier_farthest_select_unit test passed");
		else
			$display("occupancy_frontier_farthest_select_unit test failed");
		$finish;
	end
endmodule
